/* sv/kpdr_pkg.sv */
// Package for the keypad to pulse-distance remote encoder.
// Holds the transaction payload types, key and command tables and the sequencer states.
// No dependencies.
package kpdr_pkg;

  localparam int KEY_W = 4;
  localparam int CMD_W = 5;

  localparam logic [4:0] HDR_MARK  = 5'd16;
  localparam logic [3:0] HDR_SPACE = 4'd8;
  localparam logic [3:0] RPT_SPACE = 4'd4;
  localparam logic [3:0] ONE_SPACE = 4'd3;
  localparam logic [3:0] ZERO_SPACE = 4'd1;
  localparam logic [4:0] BIT_MARK  = 5'd1;
  localparam logic [3:0] TRL_SPACE = 4'd0;

  localparam logic [7:0] ADDR_FIRST_RESET  = 8'h86;
  localparam logic [7:0] ADDR_SECOND_RESET = 8'h72;

  localparam logic CFG_ADDR_FIRST  = 1'b0;
  localparam logic CFG_ADDR_SECOND = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic             held_first_check;
    logic             held_second_check;
  } in_t;

  typedef struct packed {
    logic [4:0] mark_units;
    logic [3:0] space_units;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_DUAL  = 2'd1,
    KIND_ENC   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_HDR   = 3'd1,
    ST_BITS  = 3'd2,
    ST_RPT   = 3'd3,
    ST_TRAIL = 3'd4
  } state_t;

  typedef struct packed {
    logic       full;
    logic       rpt;
    logic [7:0] code;
  } dec_t;

  function automatic kind_t kind_of_key(input logic [KEY_W-1:0] key);
    kind_t k;
    case (key)
      4'd0, 4'd1, 4'd2: k = KIND_ENC;
      4'd3: k = KIND_DUAL;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: k = KIND_PLAIN;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [CMD_W-1:0] cmd_a(input logic [KEY_W-1:0] key);
    logic [CMD_W-1:0] c;
    case (key)
      4'd3: c = 5'd10;
      4'd4: c = 5'd6;
      4'd5: c = 5'd7;
      4'd6: c = 5'd3;
      4'd7: c = 5'd9;
      4'd8: c = 5'd4;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  function automatic logic [CMD_W-1:0] cmd_b(input logic [KEY_W-1:0] key);
    logic [CMD_W-1:0] c;
    case (key)
      4'd0, 4'd1, 4'd2: c = 5'd1;
      4'd3: c = 5'd5;
      4'd4: c = 5'd6;
      4'd5: c = 5'd7;
      4'd6: c = 5'd3;
      4'd7: c = 5'd9;
      4'd8: c = 5'd4;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cmd_code(input logic [CMD_W-1:0] cmd);
    logic [7:0] c;
    case (cmd)
      5'd0:  c = 8'h14;
      5'd1:  c = 8'h15;
      5'd2:  c = 8'h16;
      5'd3:  c = 8'h0E;
      5'd4:  c = 8'h0F;
      5'd5:  c = 8'h0A;
      5'd6:  c = 8'h12;
      5'd7:  c = 8'h13;
      5'd8:  c = 8'h09;
      5'd9:  c = 8'h07;
      5'd10: c = 8'h0D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] enc_next(input logic [1:0] v);
    logic [1:0] n;
    case (v)
      2'd0: n = 2'd1;
      2'd1: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* sv/kpdr_decode.sv */
// Key event decoder: maps a key transaction to a full frame, a repeat frame or nothing.
// Keeps the last encoder contact. Depends on kpdr_pkg.
module kpdr_decode #(
  parameter int NUM_KEYS     = 9,
  parameter int NUM_COMMANDS = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  kpdr_pkg::in_t item,
  input  logic          accept,
  output kpdr_pkg::dec_t dec
);

  logic       enc_last_valid;
  logic [1:0] enc_last_key;

  kpdr_pkg::kind_t               kind;
  logic                          in_range;
  logic                          sel;
  logic [kpdr_pkg::CMD_W-1:0]    cmd;
  logic                          cmd_ok;
  logic                          enc_upd;

  always_comb begin
    kind     = kpdr_pkg::kind_of_key(item.key);
    in_range = {1'b0, item.key} < 5'(NUM_KEYS);
    sel      = 1'b0;
    cmd      = kpdr_pkg::cmd_a(item.key);
    case (kind)
      kpdr_pkg::KIND_PLAIN: begin
        sel = 1'b1;
      end
      kpdr_pkg::KIND_DUAL: begin
        sel = 1'b1;
        if (!item.held_first_check && item.held_second_check) begin
          cmd = kpdr_pkg::cmd_b(item.key);
        end
      end
      kpdr_pkg::KIND_ENC: begin
        if (enc_last_valid && kpdr_pkg::enc_next(enc_last_key) == item.key[1:0]) begin
          sel = 1'b1;
        end else if (enc_last_valid &&
                     kpdr_pkg::enc_next(item.key[1:0]) == enc_last_key) begin
          sel = 1'b1;
          cmd = kpdr_pkg::cmd_b(item.key);
        end
      end
      default: begin
        sel = 1'b0;
      end
    endcase
    cmd_ok   = {1'b0, cmd} < 6'(NUM_COMMANDS);
    dec.full = !item.mode && in_range && sel && cmd_ok;
    dec.rpt  = item.mode && in_range &&
               (kind == kpdr_pkg::KIND_PLAIN || kind == kpdr_pkg::KIND_DUAL);
    dec.code = kpdr_pkg::cmd_code(cmd);
    enc_upd  = accept && !item.mode && in_range && kind == kpdr_pkg::KIND_ENC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_last_valid <= 1'b0;
      enc_last_key   <= 2'd0;
    end else if (enc_upd) begin
      enc_last_valid <= 1'b1;
      enc_last_key   <= item.key[1:0];
    end
  end

endmodule

/* sv/kpdr_frame_seq.sv */
// Frame sequencer: one shift register and a bit counter emit the frame pair by pair.
// Holds the output register. Depends on kpdr_pkg.
module kpdr_frame_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kpdr_pkg::dec_t dec,
  input  logic [7:0]     addr_first,
  input  logic [7:0]     addr_second,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_ready,
  output kpdr_pkg::out_t out_data
);

  kpdr_pkg::state_t state;
  kpdr_pkg::state_t state_next;
  logic [31:0]      frame_bits;
  logic [4:0]       bit_cnt;
  logic             adv;
  kpdr_pkg::out_t   pair;

  assign busy = state != kpdr_pkg::ST_IDLE;
  assign adv  = busy && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      kpdr_pkg::ST_IDLE: begin
        if (start && dec.full) begin
          state_next = kpdr_pkg::ST_HDR;
        end else if (start && dec.rpt) begin
          state_next = kpdr_pkg::ST_RPT;
        end
      end
      kpdr_pkg::ST_HDR: begin
        if (adv) state_next = kpdr_pkg::ST_BITS;
      end
      kpdr_pkg::ST_BITS: begin
        if (adv && bit_cnt == 5'd31) state_next = kpdr_pkg::ST_TRAIL;
      end
      kpdr_pkg::ST_RPT: begin
        if (adv) state_next = kpdr_pkg::ST_TRAIL;
      end
      kpdr_pkg::ST_TRAIL: begin
        if (adv) state_next = kpdr_pkg::ST_IDLE;
      end
      default: begin
        state_next = kpdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pair.mark_units  = kpdr_pkg::BIT_MARK;
    pair.space_units = kpdr_pkg::TRL_SPACE;
    pair.last        = 1'b0;
    case (state)
      kpdr_pkg::ST_HDR: begin
        pair.mark_units  = kpdr_pkg::HDR_MARK;
        pair.space_units = kpdr_pkg::HDR_SPACE;
      end
      kpdr_pkg::ST_BITS: begin
        pair.space_units = frame_bits[0] ? kpdr_pkg::ONE_SPACE : kpdr_pkg::ZERO_SPACE;
      end
      kpdr_pkg::ST_RPT: begin
        pair.mark_units  = kpdr_pkg::HDR_MARK;
        pair.space_units = kpdr_pkg::RPT_SPACE;
      end
      kpdr_pkg::ST_TRAIL: begin
        pair.last = 1'b1;
      end
      default: begin
        pair.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kpdr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= 5'd0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == kpdr_pkg::ST_IDLE) begin
        bit_cnt <= 5'd0;
      end else if (adv && state == kpdr_pkg::ST_BITS) begin
        bit_cnt <= bit_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= pair;
    end
    if (state == kpdr_pkg::ST_IDLE && start && dec.full) begin
      frame_bits <= {~dec.code, dec.code, addr_second, addr_first};
    end else if (adv && state == kpdr_pkg::ST_BITS) begin
      frame_bits <= {1'b0, frame_bits[31:1]};
    end
  end

  a_trail_ends: assert property (@(posedge clk) disable iff (rst)
    (state == kpdr_pkg::ST_TRAIL && adv) |=>
      (state == kpdr_pkg::ST_IDLE && out_valid && out_data.last))
    else $error("Trailer pair did not end the frame.");

  a_bits_count: assert property (@(posedge clk) disable iff (rst)
    (state == kpdr_pkg::ST_BITS && adv && bit_cnt == 5'd31) |=> state == kpdr_pkg::ST_TRAIL)
    else $error("Data bits did not end after 32 pairs.");

  a_zero_space_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.space_units == kpdr_pkg::TRL_SPACE) |-> out_data.last)
    else $error("Zero space appeared on a pair that is not the last.");

  a_idle_no_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == kpdr_pkg::ST_HDR || state == kpdr_pkg::ST_RPT) |-> bit_cnt == 5'd0)
    else $error("Bit counter not cleared at frame start.");

endmodule

/* sv/keypad_to_pulse_distance_remote_core.sv */
// Top level of the keypad to pulse-distance remote encoder.
// Instantiates kpdr_decode and kpdr_frame_seq and holds the address registers.
// Depends on kpdr_pkg.
//
// Usage: one key event is a transaction on the in channel (in_valid/in_ready, in_data).
// Each event yields a full frame of 34 (mark, space) pairs, a repeat frame of 2 pairs,
// or nothing. Pairs leave one per transaction on the out channel (out_valid/out_ready,
// out_data); last marks the final pair of a frame.
// A full frame is paced by the frame sequencer, which emits one pair per cycle, while
// out_ready is held high, from a 32-bit shift register. On an accepted transaction it
// moves from idle to the header state, then through the data bits to the trailer; a
// repeat frame moves from the repeat state to the trailer. Each pair is registered
// into the output register. An event that sends nothing leaves the sequencer idle.
// in_ready is low while a frame is being sent.
// When the receiver holds out_ready low, the output register keeps its pair and the
// sequencer waits; nothing is dropped.
// The user must write the address registers (cfg_we, cfg_index, cfg_data) while idle;
// the block does not enforce it. Reset (rst, synchronous) restores address bytes 0x86
// and 0x72, forgets the last encoder contact and empties the output register.
module keypad_to_pulse_distance_remote_core #(
  parameter int NUM_KEYS     = 9,
  parameter int NUM_COMMANDS = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kpdr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kpdr_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  logic [7:0]     address_byte_first;
  logic [7:0]     address_byte_second;
  logic           accept;
  logic           busy;
  kpdr_pkg::dec_t dec;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte_first  <= kpdr_pkg::ADDR_FIRST_RESET;
      address_byte_second <= kpdr_pkg::ADDR_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kpdr_pkg::CFG_ADDR_FIRST:  address_byte_first  <= cfg_data;
        kpdr_pkg::CFG_ADDR_SECOND: address_byte_second <= cfg_data;
        default: address_byte_first <= address_byte_first;
      endcase
    end
  end

  kpdr_decode #(
    .NUM_KEYS     (NUM_KEYS),
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .item   (in_data),
    .accept (accept),
    .dec    (dec)
  );

  kpdr_frame_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .dec         (dec),
    .addr_first  (address_byte_first),
    .addr_second (address_byte_second),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
